/* hdl/cartridge_bank_mapper_with_irq_counter_assert.svh */
// Assertion macros shared by the cartridge bank mapper RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_COUNTER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_COUNTER_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define CBM_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("cbm assertion failed: same-cycle implication");

// The condition implies the expression in the next cycle.
`define CBM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("cbm assertion failed: next-cycle implication");

`endif

/* hdl/cbm_pkg.sv */
// Shared types and constants of the cartridge bank mapper.
// Used by cbm_core and the top level; depends on nothing else.
package cbm_pkg;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int BANK_W  = 8;
    localparam int CNT_W   = 15;
    localparam int CFG_W   = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Write decode addresses.
    localparam logic [ADDR_W-1:0] CHR_ADDR    = 16'h8000;
    localparam logic [ADDR_W-1:0] SRAM_ADDR   = 16'hF000;
    localparam logic [ADDR_W-1:0] DECODE_MASK = 16'hE003;
    localparam logic [ADDR_W-1:0] PRG_WIN_SEL = 16'hE000;
    localparam logic [ADDR_W-1:0] MIRROR_SEL  = 16'hE001;
    localparam logic [ADDR_W-1:0] IRQ_SEL     = 16'hE002;

    localparam int MIRROR_BIT = 3;
    localparam int IRQ_EN_BIT = 1;
    localparam int IRQ_MSB    = 14;
    localparam int IRQ_LSB    = 13;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_TICK  = 1'b1
    } func_t;

    typedef enum logic
    {
        CFG_CHR_USES_ROM   = 1'b0,
        CFG_FIXED_PRG_BANK = 1'b1
    } cfg_index_t;

    // Mapper state as seen by the result of one item.
    typedef struct packed
    {
        logic              irq_line;
        logic [BANK_W-1:0] sram_page;
        logic              mirror_horizontal;
        logic [BANK_W-1:0] prg_window_bank;
        logic [BANK_W-1:0] chr_bank;
    } cbm_state_t;

endpackage

/* hdl/cbm_core.sv */
// Mapper register file, write decode and IRQ tick counter.
// Depends on cbm_pkg and the assertion macro header.
`include "cartridge_bank_mapper_with_irq_counter_assert.svh"

module cbm_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  cbm_pkg::func_t             func,
    input  logic [cbm_pkg::ADDR_W-1:0] address,
    input  logic [cbm_pkg::DATA_W-1:0] data_value,
    output cbm_pkg::cbm_state_t        state_next
);
    import cbm_pkg::*;

    logic [BANK_W-1:0] chr_bank_reg,    chr_bank_next;
    logic [BANK_W-1:0] prg_window_reg,  prg_window_next;
    logic              mirror_reg,      mirror_next;
    logic [BANK_W-1:0] sram_page_reg,   sram_page_next;
    logic              irq_enabled_reg, irq_enabled_next;
    logic [CNT_W-1:0]  counter_reg,     counter_next;
    logic              irq_pending_reg, irq_pending_next;
    logic [ADDR_W-1:0] decode_sel;

    assign decode_sel = address & DECODE_MASK;

    always_comb
    begin
        chr_bank_next    = chr_bank_reg;
        prg_window_next  = prg_window_reg;
        mirror_next      = mirror_reg;
        sram_page_next   = sram_page_reg;
        irq_enabled_next = irq_enabled_reg;
        counter_next     = counter_reg;
        irq_pending_next = irq_pending_reg;
        if (step_en)
        begin
            if (func == FUNC_TICK)
            begin
                if (irq_enabled_reg)
                begin
                    counter_next = counter_reg + CNT_W'(1);
                    if (counter_next[IRQ_MSB:IRQ_LSB] != counter_reg[IRQ_MSB:IRQ_LSB])
                    begin
                        irq_pending_next = &counter_next[IRQ_MSB:IRQ_LSB];
                    end
                end
            end
            else
            begin
                priority if (address == CHR_ADDR)
                begin
                    chr_bank_next = data_value;
                end
                else if (address == SRAM_ADDR)
                begin
                    sram_page_next = data_value;
                end
                else
                begin
                    unique case (decode_sel)
                        PRG_WIN_SEL: prg_window_next = data_value;
                        MIRROR_SEL:  mirror_next     = data_value[MIRROR_BIT];
                        IRQ_SEL:
                        begin
                            irq_enabled_next = data_value[IRQ_EN_BIT];
                            if (!data_value[IRQ_EN_BIT])
                            begin
                                counter_next = '0;
                            end
                            irq_pending_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_bank_reg    <= '0;
            prg_window_reg  <= '0;
            mirror_reg      <= 1'b0;
            sram_page_reg   <= '0;
            irq_enabled_reg <= 1'b0;
            counter_reg     <= '0;
            irq_pending_reg <= 1'b0;
        end
        else
        begin
            chr_bank_reg    <= chr_bank_next;
            prg_window_reg  <= prg_window_next;
            mirror_reg      <= mirror_next;
            sram_page_reg   <= sram_page_next;
            irq_enabled_reg <= irq_enabled_next;
            counter_reg     <= counter_next;
            irq_pending_reg <= irq_pending_next;
        end
    end

    assign state_next.chr_bank          = chr_bank_next;
    assign state_next.prg_window_bank   = prg_window_next;
    assign state_next.mirror_horizontal = mirror_next;
    assign state_next.sram_page         = sram_page_next;
    assign state_next.irq_line          = irq_pending_next;

    // A pending interrupt can only exist while the counter runs.
    `CBM_ASSERT_SAME(a_irq_needs_enable, clk, rst_n, irq_pending_reg, irq_enabled_reg)
    // A stopped counter is held at zero.
    `CBM_ASSERT_SAME(a_idle_counter_zero, clk, rst_n, !irq_enabled_reg, counter_reg == '0)
    // The interrupt is only up while the top two counter bits are both set.
    `CBM_ASSERT_SAME(a_irq_in_window, clk, rst_n, irq_pending_reg, &counter_reg[IRQ_MSB:IRQ_LSB])
    // An enabled tick advances the counter by exactly one.
    `CBM_ASSERT_NEXT(a_tick_advance, clk, rst_n, step_en && func == FUNC_TICK && irq_enabled_reg,
                     counter_reg == CNT_W'($past(counter_reg) + CNT_W'(1)))

endmodule

/* hdl/cartridge_bank_mapper_with_irq_counter.sv */
// Top level of the cartridge bank mapper with IRQ counter.
// Depends on cbm_pkg and cbm_core.
//
// Usage: each item on the slave stream is either a CPU write into the cartridge
// register space (tuser = 0, tdata carries address and data) or one CPU clock
// tick (tuser = 1, tdata ignored). Every item yields exactly one item on the
// master stream that shows the bank numbers, mirroring and IRQ line as they
// stand after that item has taken effect.
// The fixed 32K program bank is set through the configuration write port,
// which may only be used while no item is in flight.
// An accepted item first waits in the input register, then the decode and
// counter update load the result register. Throughput is one item per cycle
// while the receiver does not stall; the mapper registers and the 15-bit
// counter are updated exactly once per item as it moves to the result register.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item, so the sender sees backpressure only
// after both stages are full. Reset clears all mapper state to zero (vertical
// mirroring, counter stopped) and the fixed program bank to zero, and empties
// both stages. The graphics source select register does not change any bank
// number, so it is accepted on the port but not kept.

module cartridge_bank_mapper_with_irq_counter
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Slave stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: address [15:0], data_value [23:16]
    input  logic [cbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: func [0]
    input  logic                            s_axis_tuser,
    // Master stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: chr_bank [7:0], prg_window_bank [15:8], prg_high_bank [23:16],
    //        mirror_horizontal [24], sram_page [32:25], irq_line [33], zeros [39:34]
    output logic [cbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration write port.
    input  logic                            cfg_wen,
    input  cbm_pkg::cfg_index_t             cfg_index,
    input  logic [cbm_pkg::CFG_W-1:0]       cfg_data
);
    import cbm_pkg::*;

    // Configuration.
    logic [BANK_W-1:0] fixed_prg_reg;

    // Input stage.
    logic              in_valid_reg;
    func_t             in_func_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;

    // Result stage.
    logic              out_valid_reg;
    cbm_state_t        out_state_reg;
    logic [BANK_W-1:0] out_prg_high_reg;

    logic              advance;
    logic              in_take;
    cbm_state_t        state_next;

    // The input item moves on whenever the result register is free or drains.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_prg_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_CHR_USES_ROM:   ;
                CFG_FIXED_PRG_BANK: fixed_prg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg <= func_t'(s_axis_tuser);
            in_addr_reg <= s_axis_tdata[ADDR_W-1:0];
            in_data_reg <= s_axis_tdata[ADDR_W +: DATA_W];
        end
    end

    // The mapper state updates exactly once per item, when it leaves the
    // input register for the result register.
    cbm_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .func       (in_func_reg),
        .address    (in_addr_reg),
        .data_value (in_data_reg),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_state_reg    <= state_next;
            out_prg_high_reg <= fixed_prg_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - 34)'(0),
                            out_state_reg.irq_line,
                            out_state_reg.sram_page,
                            out_state_reg.mirror_horizontal,
                            out_prg_high_reg,
                            out_state_reg.prg_window_bank,
                            out_state_reg.chr_bank};

endmodule
